// ===== sv/pv2hp_pkg.sv =====
// Shared types, codes and lookup functions for the PROXY v2 header parser.
package pv2hp_pkg;

    localparam int MAX_HEADER_BYTES = 1024;
    localparam int OFF_W            = $clog2(MAX_HEADER_BYTES + 1);

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 5;

    localparam logic [4:0] TAG_SIG        = 5'd0;
    localparam logic [4:0] TAG_VERCMD     = 5'd1;
    localparam logic [4:0] TAG_FAMILY     = 5'd2;
    localparam logic [4:0] TAG_LENGTH     = 5'd3;
    localparam logic [4:0] TAG_SRC_ADDR   = 5'd4;
    localparam logic [4:0] TAG_DST_ADDR   = 5'd5;
    localparam logic [4:0] TAG_SRC_PORT   = 5'd6;
    localparam logic [4:0] TAG_DST_PORT   = 5'd7;
    localparam logic [4:0] TAG_UNIX       = 5'd8;
    localparam logic [4:0] TAG_TLV_TYPE   = 5'd9;
    localparam logic [4:0] TAG_TLV_LEN    = 5'd10;
    localparam logic [4:0] TAG_TLV_VALUE  = 5'd11;
    localparam logic [4:0] TAG_SSL_CLIENT = 5'd12;
    localparam logic [4:0] TAG_SSL_VERIFY = 5'd13;
    localparam logic [4:0] TAG_SUB_TYPE   = 5'd14;
    localparam logic [4:0] TAG_SUB_LEN    = 5'd15;
    localparam logic [4:0] TAG_SUB_VALUE  = 5'd16;
    localparam logic [4:0] TAG_TRAILING   = 5'd17;
    localparam logic [4:0] TAG_IGNORED    = 5'd18;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_V1      = 4'd2;
    localparam logic [3:0] ST_SIG     = 4'd3;
    localparam logic [3:0] ST_VERSION = 4'd4;
    localparam logic [3:0] ST_LOCAL   = 4'd5;
    localparam logic [3:0] ST_COMMAND = 4'd6;
    localparam logic [3:0] ST_UNSPEC  = 4'd7;
    localparam logic [3:0] ST_FAMILY  = 4'd8;
    localparam logic [3:0] ST_LENGTH  = 4'd9;
    localparam logic [3:0] ST_TRUNC   = 4'd10;
    localparam logic [3:0] ST_TLV     = 4'd11;

    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_CLIENT = 3'd4;
    localparam logic [2:0] PH_VERIFY = 3'd5;
    localparam logic [2:0] PH_DEAD   = 3'd6;
    localparam logic [2:0] PH_SUBS   = 3'd7;

    localparam logic [1:0] SP_TYPE   = 2'd0;
    localparam logic [1:0] SP_LEN_HI = 2'd1;
    localparam logic [1:0] SP_LEN_LO = 2'd2;
    localparam logic [1:0] SP_VALUE  = 2'd3;

    localparam logic [7:0] SSL_TLV_TYPE = 8'h20;

    typedef struct packed {
        logic [4:0]  byte_tag;
        logic [7:0]  tlv_kind;
        logic [7:0]  sub_kind;
        logic        end_of_input;
        logic [3:0]  status;
        logic [2:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [31:0] source_ipv4;
        logic [31:0] destination_ipv4;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h0D;
            4'd1:    b = 8'h0A;
            4'd2:    b = 8'h0D;
            4'd3:    b = 8'h0A;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h0D;
            4'd6:    b = 8'h0A;
            4'd7:    b = 8'h51;
            4'd8:    b = 8'h55;
            4'd9:    b = 8'h49;
            4'd10:   b = 8'h54;
            4'd11:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] v1_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h50;
            4'd1:    b = 8'h52;
            4'd2:    b = 8'h4F;
            4'd3:    b = 8'h58;
            4'd4:    b = 8'h59;
            4'd5:    b = 8'h20;
            4'd6:    b = 8'h54;
            4'd7:    b = 8'h43;
            4'd8:    b = 8'h50;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/pv2hp_core.sv =====
// Parser state registers and the per-byte tagging and field collection logic.
module pv2hp_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output pv2hp_pkg::result_t     result
);

    localparam int OFF_W = pv2hp_pkg::OFF_W;
    localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(pv2hp_pkg::MAX_HEADER_BYTES);

    logic [OFF_W-1:0] off_reg, off_next;
    logic [3:0]       err_reg, err_next;
    logic             v1_reg, v1_next;
    logic             sigm_reg, sigm_next;
    logic [2:0]       fam_reg, fam_next;
    logic [7:0]       abytes_reg, abytes_next;
    logic [15:0]      ext_len_reg, ext_len_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      dport_reg, dport_next;
    logic [31:0]      saddr_reg, saddr_next;
    logic [31:0]      daddr_reg, daddr_next;
    logic [2:0]       tlv_ph_reg, tlv_ph_next;
    logic [7:0]       tlv_type_reg, tlv_type_next;
    logic [15:0]      tlv_rem_reg, tlv_rem_next;
    logic [1:0]       sub_ph_reg, sub_ph_next;
    logic [7:0]       sub_type_reg, sub_type_next;
    logic [15:0]      sub_rem_reg, sub_rem_next;

    always_comb begin
        logic [16:0]      ext_end;
        logic [16:0]      off17;
        logic [OFF_W-1:0] r;
        logic [7:0]       half;
        logic [8:0]       two_half;
        logic             is_v4;
        logic [15:0]      len16;
        logic [15:0]      tcnt;
        logic [15:0]      scnt;
        logic             do_dec;
        logic [4:0]       tag;
        logic [7:0]       kind;
        logic [7:0]       sub;
        logic [3:0]       status;

        off_next      = off_reg;
        err_next      = err_reg;
        v1_next       = v1_reg;
        sigm_next     = sigm_reg;
        fam_next      = fam_reg;
        abytes_next   = abytes_reg;
        ext_len_next  = ext_len_reg;
        sport_next    = sport_reg;
        dport_next    = dport_reg;
        saddr_next    = saddr_reg;
        daddr_next    = daddr_reg;
        tlv_ph_next   = tlv_ph_reg;
        tlv_type_next = tlv_type_reg;
        tlv_rem_next  = tlv_rem_reg;
        sub_ph_next   = sub_ph_reg;
        sub_type_next = sub_type_reg;
        sub_rem_next  = sub_rem_reg;

        tag      = pv2hp_pkg::TAG_IGNORED;
        kind     = 8'd0;
        sub      = 8'd0;
        status   = pv2hp_pkg::ST_OK;
        ext_end  = 17'd16 + {1'b0, ext_len_reg};
        off17    = 17'(off_reg);
        r        = off_reg - OFF_W'(16);
        half     = 8'((abytes_reg - 8'd4) >> 1);
        two_half = {half, 1'b0};
        is_v4    = (fam_reg == 3'd1) || (fam_reg == 3'd2);
        len16    = {tlv_rem_reg[15:8], data_byte};
        tcnt     = tlv_rem_reg;
        scnt     = sub_rem_reg;
        do_dec   = 1'b0;

        if (step && (off_reg < MAX_OFF)) begin
            off_next = off_reg + OFF_W'(1);
            if (off_reg < OFF_W'(12)) begin
                tag = pv2hp_pkg::TAG_SIG;
                if (data_byte != pv2hp_pkg::sig_byte(off_reg[3:0])) begin
                    sigm_next = 1'b0;
                end
                if (off_reg < OFF_W'(9) && data_byte != pv2hp_pkg::v1_byte(off_reg[3:0])) begin
                    v1_next = 1'b0;
                end
            end else if (off_reg == OFF_W'(12)) begin
                tag = pv2hp_pkg::TAG_VERCMD;
                if (err_reg == pv2hp_pkg::ST_OK) begin
                    priority if (data_byte[7:4] != 4'h2) begin
                        err_next = pv2hp_pkg::ST_VERSION;
                    end else if (data_byte[3:0] == 4'h0) begin
                        err_next = pv2hp_pkg::ST_LOCAL;
                    end else if (data_byte[3:0] != 4'h1) begin
                        err_next = pv2hp_pkg::ST_COMMAND;
                    end
                end
            end else if (off_reg == OFF_W'(13)) begin
                tag = pv2hp_pkg::TAG_FAMILY;
                unique case (data_byte)
                    8'h11: begin fam_next = 3'd1; abytes_next = 8'd12;  end
                    8'h12: begin fam_next = 3'd2; abytes_next = 8'd12;  end
                    8'h21: begin fam_next = 3'd3; abytes_next = 8'd36;  end
                    8'h22: begin fam_next = 3'd4; abytes_next = 8'd36;  end
                    8'h31: begin fam_next = 3'd5; abytes_next = 8'd216; end
                    8'h32: begin fam_next = 3'd6; abytes_next = 8'd216; end
                    default: begin fam_next = 3'd0; abytes_next = 8'd0; end
                endcase
                if (err_reg == pv2hp_pkg::ST_OK) begin
                    if (data_byte == 8'h00) begin
                        err_next = pv2hp_pkg::ST_UNSPEC;
                    end else if (fam_next == 3'd0) begin
                        err_next = pv2hp_pkg::ST_FAMILY;
                    end
                end
            end else if (off_reg == OFF_W'(14)) begin
                tag          = pv2hp_pkg::TAG_LENGTH;
                ext_len_next = {data_byte, 8'h00};
            end else if (off_reg == OFF_W'(15)) begin
                tag          = pv2hp_pkg::TAG_LENGTH;
                ext_len_next = {ext_len_reg[15:8], data_byte};
                if (ext_len_next < {8'h00, abytes_reg} && err_reg == pv2hp_pkg::ST_OK) begin
                    err_next = pv2hp_pkg::ST_LENGTH;
                end
            end else if (!sigm_reg || (err_reg != pv2hp_pkg::ST_OK
                                       && err_reg != pv2hp_pkg::ST_TLV)) begin
                tag = pv2hp_pkg::TAG_IGNORED;
            end else if (off17 >= ext_end) begin
                tag = pv2hp_pkg::TAG_TRAILING;
            end else if (r < OFF_W'(abytes_reg)) begin
                if (fam_reg >= 3'd5) begin
                    tag = pv2hp_pkg::TAG_UNIX;
                end else if (r < OFF_W'(half)) begin
                    tag = pv2hp_pkg::TAG_SRC_ADDR;
                    if (is_v4) begin
                        saddr_next = {saddr_reg[23:0], data_byte};
                    end
                end else if (r < OFF_W'(two_half)) begin
                    tag = pv2hp_pkg::TAG_DST_ADDR;
                    if (is_v4) begin
                        daddr_next = {daddr_reg[23:0], data_byte};
                    end
                end else if (r < OFF_W'(two_half) + OFF_W'(2)) begin
                    tag        = pv2hp_pkg::TAG_SRC_PORT;
                    sport_next = {sport_reg[7:0], data_byte};
                end else begin
                    tag        = pv2hp_pkg::TAG_DST_PORT;
                    dport_next = {dport_reg[7:0], data_byte};
                end
            end else begin
                unique case (tlv_ph_reg)
                    pv2hp_pkg::PH_TYPE: begin
                        if (ext_end - off17 < 17'd4) begin
                            if (err_reg == pv2hp_pkg::ST_OK) begin
                                err_next = pv2hp_pkg::ST_TLV;
                            end
                            tlv_ph_next = pv2hp_pkg::PH_DEAD;
                        end else begin
                            tag           = pv2hp_pkg::TAG_TLV_TYPE;
                            kind          = data_byte;
                            tlv_type_next = data_byte;
                            tlv_ph_next   = pv2hp_pkg::PH_LEN_HI;
                        end
                    end
                    pv2hp_pkg::PH_LEN_HI: begin
                        tag          = pv2hp_pkg::TAG_TLV_LEN;
                        kind         = tlv_type_reg;
                        tlv_rem_next = {data_byte, 8'h00};
                        tlv_ph_next  = pv2hp_pkg::PH_LEN_LO;
                    end
                    pv2hp_pkg::PH_LEN_LO: begin
                        tag          = pv2hp_pkg::TAG_TLV_LEN;
                        kind         = tlv_type_reg;
                        tlv_rem_next = len16;
                        if (len16 == 16'd0 || {1'b0, len16} > ext_end - off17 - 17'd1) begin
                            if (err_reg == pv2hp_pkg::ST_OK) begin
                                err_next = pv2hp_pkg::ST_TLV;
                            end
                            tlv_ph_next = pv2hp_pkg::PH_DEAD;
                        end else begin
                            tlv_ph_next  = (tlv_type_reg == pv2hp_pkg::SSL_TLV_TYPE)
                                           ? pv2hp_pkg::PH_CLIENT : pv2hp_pkg::PH_VALUE;
                            sub_ph_next  = pv2hp_pkg::SP_TYPE;
                            sub_rem_next = 16'd0;
                        end
                    end
                    pv2hp_pkg::PH_VALUE: begin
                        tag    = pv2hp_pkg::TAG_TLV_VALUE;
                        do_dec = 1'b1;
                    end
                    pv2hp_pkg::PH_CLIENT: begin
                        tag          = pv2hp_pkg::TAG_SSL_CLIENT;
                        tlv_ph_next  = pv2hp_pkg::PH_VERIFY;
                        sub_rem_next = 16'd4;
                        do_dec       = 1'b1;
                    end
                    pv2hp_pkg::PH_VERIFY: begin
                        tag = pv2hp_pkg::TAG_SSL_VERIFY;
                        if (scnt != 16'd0) begin
                            scnt = scnt - 16'd1;
                        end
                        sub_rem_next = scnt;
                        if (scnt == 16'd0) begin
                            tlv_ph_next = pv2hp_pkg::PH_SUBS;
                            sub_ph_next = pv2hp_pkg::SP_TYPE;
                        end
                        do_dec = 1'b1;
                    end
                    pv2hp_pkg::PH_SUBS: begin
                        unique case (sub_ph_reg)
                            pv2hp_pkg::SP_TYPE: begin
                                tag           = pv2hp_pkg::TAG_SUB_TYPE;
                                sub_type_next = data_byte;
                                sub_ph_next   = pv2hp_pkg::SP_LEN_HI;
                            end
                            pv2hp_pkg::SP_LEN_HI: begin
                                tag          = pv2hp_pkg::TAG_SUB_LEN;
                                sub_rem_next = {data_byte, 8'h00};
                                sub_ph_next  = pv2hp_pkg::SP_LEN_LO;
                            end
                            pv2hp_pkg::SP_LEN_LO: begin
                                tag          = pv2hp_pkg::TAG_SUB_LEN;
                                sub_rem_next = {sub_rem_reg[15:8], data_byte};
                                sub_ph_next  = (sub_rem_next != 16'd0)
                                               ? pv2hp_pkg::SP_VALUE : pv2hp_pkg::SP_TYPE;
                            end
                            default: begin
                                tag = pv2hp_pkg::TAG_SUB_VALUE;
                                if (scnt != 16'd0) begin
                                    scnt = scnt - 16'd1;
                                end
                                sub_rem_next = scnt;
                                if (scnt == 16'd0) begin
                                    sub_ph_next = pv2hp_pkg::SP_TYPE;
                                end
                            end
                        endcase
                        sub    = sub_type_next;
                        do_dec = 1'b1;
                    end
                    default: begin
                        tag = pv2hp_pkg::TAG_IGNORED;
                    end
                endcase
                if (do_dec) begin
                    kind = tlv_type_reg;
                    if (tcnt != 16'd0) begin
                        tcnt = tcnt - 16'd1;
                    end
                    tlv_rem_next = tcnt;
                    if (tcnt == 16'd0) begin
                        tlv_ph_next  = pv2hp_pkg::PH_TYPE;
                        sub_ph_next  = pv2hp_pkg::SP_TYPE;
                        sub_rem_next = 16'd0;
                    end
                end
            end
        end

        priority if (off_next < OFF_W'(16)) begin
            status = pv2hp_pkg::ST_SHORT;
        end else if (v1_next) begin
            status = pv2hp_pkg::ST_V1;
        end else if (!sigm_next) begin
            status = pv2hp_pkg::ST_SIG;
        end else if (err_next != pv2hp_pkg::ST_OK && err_next != pv2hp_pkg::ST_TLV) begin
            status = err_next;
        end else if (17'd16 + {1'b0, ext_len_next} > 17'(off_next)) begin
            status = pv2hp_pkg::ST_TRUNC;
        end else begin
            status = err_next;
        end

        result.byte_tag     = tag;
        result.tlv_kind     = kind;
        result.sub_kind     = sub;
        result.end_of_input = last_byte;
        if (last_byte) begin
            result.status           = status;
            result.protocol         = (fam_next != 3'd0) ? (fam_next - 3'd1) : 3'd0;
            result.source_port      = sport_next;
            result.destination_port = dport_next;
            result.source_ipv4      = saddr_next;
            result.destination_ipv4 = daddr_next;
        end else begin
            result.status           = pv2hp_pkg::ST_OK;
            result.protocol         = 3'd0;
            result.source_port      = 16'd0;
            result.destination_port = 16'd0;
            result.source_ipv4      = 32'd0;
            result.destination_ipv4 = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            off_reg      <= '0;
            err_reg      <= pv2hp_pkg::ST_OK;
            v1_reg       <= 1'b1;
            sigm_reg     <= 1'b1;
            fam_reg      <= 3'd0;
            abytes_reg   <= 8'd0;
            ext_len_reg  <= 16'd0;
            sport_reg    <= 16'd0;
            dport_reg    <= 16'd0;
            saddr_reg    <= 32'd0;
            daddr_reg    <= 32'd0;
            tlv_ph_reg   <= pv2hp_pkg::PH_TYPE;
            tlv_type_reg <= 8'd0;
            tlv_rem_reg  <= 16'd0;
            sub_ph_reg   <= pv2hp_pkg::SP_TYPE;
            sub_type_reg <= 8'd0;
            sub_rem_reg  <= 16'd0;
        end else if (step) begin
            off_reg      <= off_next;
            err_reg      <= err_next;
            v1_reg       <= v1_next;
            sigm_reg     <= sigm_next;
            fam_reg      <= fam_next;
            abytes_reg   <= abytes_next;
            ext_len_reg  <= ext_len_next;
            sport_reg    <= sport_next;
            dport_reg    <= dport_next;
            saddr_reg    <= saddr_next;
            daddr_reg    <= daddr_next;
            tlv_ph_reg   <= tlv_ph_next;
            tlv_type_reg <= tlv_type_next;
            tlv_rem_reg  <= tlv_rem_next;
            sub_ph_reg   <= sub_ph_next;
            sub_type_reg <= sub_type_next;
            sub_rem_reg  <= sub_rem_next;
        end
    end

endmodule

// ===== sv/proxy_v2_header_parser_unit.sv =====
// Top level: input register, header parser core and result register.
//
// Usage: received header bytes enter on the s_ channel, one per transfer,
// with s_tlast on the final byte. Every accepted byte yields exactly one
// result transfer on the m_ channel: m_tuser carries the role tag of the
// byte, m_tdata the enclosing TLV and sub-TLV types, and on the tlast
// transfer also the status, protocol, ports and IPv4 addresses of the
// header. After a tlast byte the parser starts afresh for the next header.
// An accepted byte is held in the input register and parsed from there into
// the result register, which drives its result transfer. An input register
// and a result register bracket a single pass of logic, so one byte is
// taken every cycle while the result side keeps up.
// When the receiver stalls, the result is held in its register and one more
// byte can still be taken into the input register; s_tready then drops
// until the result moves on. Reset (aresetn low, synchronous) empties both
// registers and returns the parser to the start of a header.
module proxy_v2_header_parser_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pv2hp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                            s_tlast,  // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] tlv_kind, [15:8] sub_kind, [19:16] status, [22:20] protocol,
    // [38:23] source_port, [54:39] destination_port, [86:55] source_ipv4,
    // [118:87] destination_ipv4, [119] zero
    output logic [pv2hp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pv2hp_pkg::M_TUSER_W-1:0] m_tuser,  // [4:0] byte_tag
    output logic                            m_tlast   // end_of_input
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               out_vld_reg;
    pv2hp_pkg::result_t out_reg;
    pv2hp_pkg::result_t res;
    logic               advance;
    logic               fire;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    pv2hp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.byte_tag;
    assign m_tlast  = out_reg.end_of_input;
    assign m_tdata  = {1'b0,
                       out_reg.destination_ipv4,
                       out_reg.source_ipv4,
                       out_reg.destination_port,
                       out_reg.source_port,
                       out_reg.protocol,
                       out_reg.status,
                       out_reg.sub_kind,
                       out_reg.tlv_kind};

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_byte_reg) && $stable(in_last_reg))
        else $error("input register lost a waiting byte");

    a_fields_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> out_reg.status == pv2hp_pkg::ST_OK
                                 && out_reg.protocol == 3'd0
                                 && out_reg.source_ipv4 == 32'd0)
        else $error("header fields reported before the last byte");

    a_tag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= pv2hp_pkg::TAG_IGNORED)
        else $error("byte tag out of range");

    a_sig_no_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pv2hp_pkg::TAG_SIG |-> out_reg.tlv_kind == 8'd0
                                                      && out_reg.sub_kind == 8'd0)
        else $error("signature byte carries a TLV type");

endmodule

// ===== sim/tb_proxy_v2_header_parser_unit.sv =====
// Self-checking testbench for the PROXY v2 header parser unit.
module tb_proxy_v2_header_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [95:0] SIG_SEQ = 96'h0D0A0D0A000D0A515549540A;
    localparam logic [71:0] V1_SEQ  = "PROXY TCP";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [4:0] tag;
        logic [3:0] status;
    } row_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [pv2hp_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [pv2hp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [pv2hp_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                             m_tlast;

    // parser image
    logic [pv2hp_pkg::OFF_W-1:0] hdr_off;
    logic [3:0]       first_err;
    logic             v1_ok;
    logic             sig_ok;
    logic [2:0]       fam;
    logic [7:0]       addr_len;
    logic [15:0]      ext_len;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [31:0]      saddr;
    logic [31:0]      daddr;
    logic [2:0]       tphase;
    logic [7:0]       ttype;
    logic [15:0]      trem;
    logic [1:0]       sphase;
    logic [7:0]       stype;
    logic [15:0]      srem;

    pv2hp_pkg::result_t pending_results[$];
    logic [7:0]         frame_q[$];

    int mismatches   = 0;
    int bytes_sent   = 0;
    int headers_seen = 0;
    int ok_count     = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    int stall_left   = 0;

    row_t plan [23] = '{
        '{8'hFF, 1'b1, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_SHORT},
        '{8'h00, 1'b1, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_SHORT},
        '{8'h0D, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0A, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0D, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0A, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h00, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0D, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0A, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h51, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h55, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h49, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h54, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h0A, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h21, 1'b0, pv2hp_pkg::TAG_VERCMD, pv2hp_pkg::ST_OK},
        '{8'h00, 1'b0, pv2hp_pkg::TAG_FAMILY, pv2hp_pkg::ST_OK},
        '{8'h00, 1'b0, pv2hp_pkg::TAG_LENGTH, pv2hp_pkg::ST_OK},
        '{8'h00, 1'b1, pv2hp_pkg::TAG_LENGTH, pv2hp_pkg::ST_UNSPEC},
        '{8'h50, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h52, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h4F, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h58, 1'b0, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_OK},
        '{8'h59, 1'b1, pv2hp_pkg::TAG_SIG,    pv2hp_pkg::ST_SHORT}
    };

    proxy_v2_header_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void clear_parser();
        hdr_off   = '0;
        first_err = pv2hp_pkg::ST_OK;
        v1_ok     = 1'b1;
        sig_ok    = 1'b1;
        fam       = '0;
        addr_len  = '0;
        ext_len   = '0;
        sport     = '0;
        dport     = '0;
        saddr     = '0;
        daddr     = '0;
        tphase    = pv2hp_pkg::PH_TYPE;
        ttype     = '0;
        trem      = '0;
        sphase    = pv2hp_pkg::SP_TYPE;
        stype     = '0;
        srem      = '0;
    endfunction

    function automatic void flag_error(input logic [3:0] code);
        if (first_err == pv2hp_pkg::ST_OK)
            first_err = code;
    endfunction

    // One byte through the parser image; returns the result it must produce.
    function automatic pv2hp_pkg::result_t parse_byte(input logic [7:0] b, input logic last);
        pv2hp_pkg::result_t r;
        int off, ext_end, half, rel;
        logic v4;
        r = '0;
        r.byte_tag = pv2hp_pkg::TAG_IGNORED;
        r.end_of_input = last;
        if (hdr_off < pv2hp_pkg::MAX_HEADER_BYTES) begin
            off = int'(hdr_off);
            hdr_off = hdr_off + pv2hp_pkg::OFF_W'(1);
            ext_end = 16 + int'(ext_len);
            if (off < 12) begin
                r.byte_tag = pv2hp_pkg::TAG_SIG;
                if (b != SIG_SEQ[95 - 8 * off -: 8])
                    sig_ok = 1'b0;
                if (off < 9 && b != V1_SEQ[71 - 8 * off -: 8])
                    v1_ok = 1'b0;
            end else if (off == 12) begin
                r.byte_tag = pv2hp_pkg::TAG_VERCMD;
                if (b[7:4] != 4'h2)
                    flag_error(pv2hp_pkg::ST_VERSION);
                else if (b[3:0] == 4'h0)
                    flag_error(pv2hp_pkg::ST_LOCAL);
                else if (b[3:0] != 4'h1)
                    flag_error(pv2hp_pkg::ST_COMMAND);
            end else if (off == 13) begin
                r.byte_tag = pv2hp_pkg::TAG_FAMILY;
                case (b)
                    8'h11: begin fam = 3'd1; addr_len = 8'd12;  end
                    8'h12: begin fam = 3'd2; addr_len = 8'd12;  end
                    8'h21: begin fam = 3'd3; addr_len = 8'd36;  end
                    8'h22: begin fam = 3'd4; addr_len = 8'd36;  end
                    8'h31: begin fam = 3'd5; addr_len = 8'd216; end
                    8'h32: begin fam = 3'd6; addr_len = 8'd216; end
                    default: begin fam = 3'd0; addr_len = 8'd0; end
                endcase
                if (first_err == pv2hp_pkg::ST_OK) begin
                    if (b == 8'h00)
                        first_err = pv2hp_pkg::ST_UNSPEC;
                    else if (fam == 3'd0)
                        first_err = pv2hp_pkg::ST_FAMILY;
                end
            end else if (off == 14) begin
                r.byte_tag = pv2hp_pkg::TAG_LENGTH;
                ext_len = {b, 8'h00};
            end else if (off == 15) begin
                r.byte_tag = pv2hp_pkg::TAG_LENGTH;
                ext_len[7:0] = b;
                if (ext_len < {8'h00, addr_len})
                    flag_error(pv2hp_pkg::ST_LENGTH);
            end else if (!sig_ok || (first_err != pv2hp_pkg::ST_OK
                                     && first_err != pv2hp_pkg::ST_TLV)) begin
                r.byte_tag = pv2hp_pkg::TAG_IGNORED;
            end else if (off >= ext_end) begin
                r.byte_tag = pv2hp_pkg::TAG_TRAILING;
            end else if (off - 16 < int'(addr_len)) begin
                rel = off - 16;
                v4 = (fam == 3'd1 || fam == 3'd2);
                half = (int'(addr_len) - 4) / 2;
                if (fam >= 3'd5) begin
                    r.byte_tag = pv2hp_pkg::TAG_UNIX;
                end else if (rel < half) begin
                    if (v4)
                        saddr = {saddr[23:0], b};
                    r.byte_tag = pv2hp_pkg::TAG_SRC_ADDR;
                end else if (rel < 2 * half) begin
                    if (v4)
                        daddr = {daddr[23:0], b};
                    r.byte_tag = pv2hp_pkg::TAG_DST_ADDR;
                end else if (rel < 2 * half + 2) begin
                    sport = {sport[7:0], b};
                    r.byte_tag = pv2hp_pkg::TAG_SRC_PORT;
                end else begin
                    dport = {dport[7:0], b};
                    r.byte_tag = pv2hp_pkg::TAG_DST_PORT;
                end
            end else begin
                case (tphase)
                    pv2hp_pkg::PH_TYPE: begin
                        if (ext_end - off < 4) begin
                            flag_error(pv2hp_pkg::ST_TLV);
                            tphase = pv2hp_pkg::PH_DEAD;
                            r.byte_tag = pv2hp_pkg::TAG_IGNORED;
                        end else begin
                            ttype = b;
                            tphase = pv2hp_pkg::PH_LEN_HI;
                            r.tlv_kind = b;
                            r.byte_tag = pv2hp_pkg::TAG_TLV_TYPE;
                        end
                    end
                    pv2hp_pkg::PH_LEN_HI: begin
                        trem = {b, 8'h00};
                        tphase = pv2hp_pkg::PH_LEN_LO;
                        r.tlv_kind = ttype;
                        r.byte_tag = pv2hp_pkg::TAG_TLV_LEN;
                    end
                    pv2hp_pkg::PH_LEN_LO: begin
                        trem[7:0] = b;
                        r.tlv_kind = ttype;
                        r.byte_tag = pv2hp_pkg::TAG_TLV_LEN;
                        if (trem == 16'd0 || int'(trem) > ext_end - off - 1) begin
                            flag_error(pv2hp_pkg::ST_TLV);
                            tphase = pv2hp_pkg::PH_DEAD;
                        end else begin
                            tphase = (ttype == pv2hp_pkg::SSL_TLV_TYPE)
                                     ? pv2hp_pkg::PH_CLIENT : pv2hp_pkg::PH_VALUE;
                            sphase = pv2hp_pkg::SP_TYPE;
                            srem = '0;
                        end
                    end
                    pv2hp_pkg::PH_DEAD: begin
                        r.byte_tag = pv2hp_pkg::TAG_IGNORED;
                    end
                    default: begin
                        case (tphase)
                            pv2hp_pkg::PH_VALUE: r.byte_tag = pv2hp_pkg::TAG_TLV_VALUE;
                            pv2hp_pkg::PH_CLIENT: begin
                                tphase = pv2hp_pkg::PH_VERIFY;
                                srem = 16'd4;
                                r.byte_tag = pv2hp_pkg::TAG_SSL_CLIENT;
                            end
                            pv2hp_pkg::PH_VERIFY: begin
                                if (srem != 16'd0)
                                    srem = srem - 16'd1;
                                if (srem == 16'd0) begin
                                    tphase = pv2hp_pkg::PH_SUBS;
                                    sphase = pv2hp_pkg::SP_TYPE;
                                end
                                r.byte_tag = pv2hp_pkg::TAG_SSL_VERIFY;
                            end
                            default: begin
                                case (sphase)
                                    pv2hp_pkg::SP_TYPE: begin
                                        stype = b;
                                        sphase = pv2hp_pkg::SP_LEN_HI;
                                        r.byte_tag = pv2hp_pkg::TAG_SUB_TYPE;
                                    end
                                    pv2hp_pkg::SP_LEN_HI: begin
                                        srem = {b, 8'h00};
                                        sphase = pv2hp_pkg::SP_LEN_LO;
                                        r.byte_tag = pv2hp_pkg::TAG_SUB_LEN;
                                    end
                                    pv2hp_pkg::SP_LEN_LO: begin
                                        srem[7:0] = b;
                                        sphase = (srem != 16'd0)
                                                 ? pv2hp_pkg::SP_VALUE : pv2hp_pkg::SP_TYPE;
                                        r.byte_tag = pv2hp_pkg::TAG_SUB_LEN;
                                    end
                                    default: begin
                                        if (srem != 16'd0)
                                            srem = srem - 16'd1;
                                        if (srem == 16'd0)
                                            sphase = pv2hp_pkg::SP_TYPE;
                                        r.byte_tag = pv2hp_pkg::TAG_SUB_VALUE;
                                    end
                                endcase
                                r.sub_kind = stype;
                            end
                        endcase
                        r.tlv_kind = ttype;
                        if (trem != 16'd0)
                            trem = trem - 16'd1;
                        if (trem == 16'd0) begin
                            tphase = pv2hp_pkg::PH_TYPE;
                            sphase = pv2hp_pkg::SP_TYPE;
                            srem = '0;
                        end
                    end
                endcase
            end
        end
        if (last) begin
            if (hdr_off < 16)
                r.status = pv2hp_pkg::ST_SHORT;
            else if (v1_ok)
                r.status = pv2hp_pkg::ST_V1;
            else if (!sig_ok)
                r.status = pv2hp_pkg::ST_SIG;
            else if (first_err != pv2hp_pkg::ST_OK && first_err != pv2hp_pkg::ST_TLV)
                r.status = first_err;
            else if (16 + int'(ext_len) > int'(hdr_off))
                r.status = pv2hp_pkg::ST_TRUNC;
            else
                r.status = first_err;
            r.protocol = (fam != 3'd0) ? fam - 3'd1 : 3'd0;
            r.source_port = sport;
            r.destination_port = dport;
            r.source_ipv4 = saddr;
            r.destination_ipv4 = daddr;
            headers_seen++;
            if (r.status == pv2hp_pkg::ST_OK)
                ok_count++;
            clear_parser();
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_signature();
        int i;
        for (i = 0; i < 12; i++)
            frame_q.push_back(SIG_SEQ[95 - 8 * i -: 8]);
    endfunction

    // Mostly well-formed headers with random content; some noise and broken ones.
    task automatic build_header();
        int pick, n, i, style, extra, len, tlvs;
        logic [7:0] fam_b, ver_b;
        logic [15:0] hdr_len;
        logic [7:0] area[$];
        logic [7:0] val[$];
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick < 7) begin
            n = $urandom_range(1, 40);
            repeat (n) frame_q.push_back(rand_byte());
            return;
        end
        if (pick < 11) begin
            for (i = 0; i < 9; i++)
                frame_q.push_back(V1_SEQ[71 - 8 * i -: 8]);
            repeat ($urandom_range(0, 20)) frame_q.push_back(rand_byte());
            return;
        end
        push_signature();
        if ($urandom_range(99) < 6) begin
            i = $urandom_range(11);
            frame_q[i] = frame_q[i] ^ (8'h01 << $urandom_range(7));
        end
        pick = $urandom_range(99);
        if (pick < 82)
            ver_b = 8'h21;
        else if (pick < 88)
            ver_b = 8'h20;
        else if (pick < 94)
            ver_b = {4'h2, 4'($urandom_range(2, 15))};
        else
            ver_b = rand_byte();
        frame_q.push_back(ver_b);
        pick = $urandom_range(99);
        if (pick < 40)
            fam_b = 8'h11;
        else if (pick < 55)
            fam_b = 8'h12;
        else if (pick < 72)
            fam_b = 8'h21;
        else if (pick < 82)
            fam_b = 8'h22;
        else if (pick < 86)
            fam_b = ($urandom_range(1) != 0) ? 8'h31 : 8'h32;
        else if (pick < 90)
            fam_b = 8'h00;
        else
            fam_b = rand_byte();
        frame_q.push_back(fam_b);
        case (fam_b)
            8'h11, 8'h12: len = 12;
            8'h21, 8'h22: len = 36;
            8'h31, 8'h32: len = 216;
            default:      len = 0;
        endcase
        n = len;

        tlvs = $urandom_range(0, 3);
        repeat (tlvs) begin
            if ($urandom_range(99) < 35) begin
                val.delete();
                if ($urandom_range(99) < 10) begin
                    repeat ($urandom_range(1, 4)) val.push_back(rand_byte());
                end else begin
                    repeat (5) val.push_back(rand_byte());
                    repeat ($urandom_range(0, 2)) begin
                        len = $urandom_range(0, 4);
                        val.push_back(rand_byte());
                        val.push_back(8'h00);
                        val.push_back(len[7:0]);
                        repeat (len) val.push_back(rand_byte());
                    end
                    // sub-TLV overrunning the end of the SSL TLV
                    if ($urandom_range(99) < 15) begin
                        val.push_back(rand_byte());
                        val.push_back(8'h00);
                        val.push_back(8'h09);
                        val.push_back(rand_byte());
                    end
                end
                len = val.size();
                area.push_back(pv2hp_pkg::SSL_TLV_TYPE);
                area.push_back(8'h00);
                area.push_back(len[7:0]);
                foreach (val[j])
                    area.push_back(val[j]);
            end else begin
                len = $urandom_range(1, 8);
                area.push_back(rand_byte());
                area.push_back(8'h00);
                area.push_back(len[7:0]);
                repeat (len) area.push_back(rand_byte());
            end
        end
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
                0: begin
                    area.push_back(rand_byte());
                    area.push_back(8'h00);
                    area.push_back(8'h00);
                    repeat ($urandom_range(0, 3)) area.push_back(rand_byte());
                end
                1: begin
                    extra = $urandom_range(0, 3);
                    len = extra + 1 + $urandom_range(0, 300);
                    area.push_back(rand_byte());
                    area.push_back(len[15:8]);
                    area.push_back(len[7:0]);
                    repeat (extra) area.push_back(rand_byte());
                end
                default: repeat ($urandom_range(1, 3)) area.push_back(rand_byte());
            endcase
        end

        hdr_len = 16'(n + area.size());
        pick = $urandom_range(99);
        if (pick < 3)
            hdr_len = 16'($urandom_range(0, n));
        else if (pick < 6)
            hdr_len = 16'($urandom_range(65535));
        frame_q.push_back(hdr_len[15:8]);
        frame_q.push_back(hdr_len[7:0]);

        style = $urandom_range(9);
        repeat (n) begin
            if (style == 0)
                frame_q.push_back(8'h00);
            else if (style == 1)
                frame_q.push_back(8'hFF);
            else
                frame_q.push_back(rand_byte());
        end
        foreach (area[j])
            frame_q.push_back(area[j]);

        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(rand_byte());
        end else if (pick < 30) begin
            n = $urandom_range(1, 20);
            while (n > 0 && frame_q.size() > 1) begin
                void'(frame_q.pop_back());
                n--;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed = 1'b0,
                             input logic [4:0] tag = '0, input logic [3:0] st = '0);
        pv2hp_pkg::result_t want;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = parse_byte(b, last);
        if (typed) begin
            want.byte_tag = tag;
            want.status = st;
        end
        pending_results.push_back(want);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input pv2hp_pkg::result_t want);
        cmp_field("byte_tag",         32'(want.byte_tag),         32'(m_tuser[4:0]));
        cmp_field("tlv_kind",         32'(want.tlv_kind),         32'(m_tdata[7:0]));
        cmp_field("sub_kind",         32'(want.sub_kind),         32'(m_tdata[15:8]));
        cmp_field("end_of_input",     32'(want.end_of_input),     32'(m_tlast));
        cmp_field("status",           32'(want.status),           32'(m_tdata[19:16]));
        cmp_field("protocol",         32'(want.protocol),         32'(m_tdata[22:20]));
        cmp_field("source_port",      32'(want.source_port),      32'(m_tdata[38:23]));
        cmp_field("destination_port", 32'(want.destination_port), 32'(m_tdata[54:39]));
        cmp_field("source_ipv4",      want.source_ipv4,           m_tdata[86:55]);
        cmp_field("destination_ipv4", want.destination_ipv4,      m_tdata[118:87]);
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no byte outstanding");
                mismatches++;
            end else begin
                check_result(pending_results.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        int k, rnd_bytes;
        bit held;
        rnd_bytes = 0;
        held = 1'b0;
        clear_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 9;
        recv_idle = 82;
        for (k = 0; k < 23; k++)
            send_byte(plan[k].data, plan[k].last, 1'b1, plan[k].tag, plan[k].status);

        while (rnd_bytes < 850) begin
            if (rnd_bytes < 280) begin
                send_idle = 9;
                recv_idle = 82;
            end else if (rnd_bytes < 560) begin
                send_idle = 82;
                recv_idle = 9;
            end else begin
                send_idle = 0;
                recv_idle = 0;
                if (!held) begin
                    stall_left = 300;
                    held = 1'b1;
                end
            end
            build_header();
            send_frame();
            rnd_bytes += frame_q.size();
        end

        // header longer than the parser's capacity
        frame_q.delete();
        push_signature();
        frame_q.push_back(8'h21);
        frame_q.push_back(8'h11);
        frame_q.push_back(8'h0F);
        frame_q.push_back(8'hFF);
        repeat (12) frame_q.push_back(rand_byte());
        frame_q.push_back(8'h01);
        frame_q.push_back(8'h0F);
        frame_q.push_back(8'hE0);
        while (frame_q.size() < pv2hp_pkg::MAX_HEADER_BYTES + 6)
            frame_q.push_back(rand_byte());
        send_frame();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d bytes in %0d headers checked; %0d parsed clean, %0d with an error status",
                 bytes_sent, headers_seen, ok_count, headers_seen - ok_count);
        $display("idle rates of 0, 9 and 82 percent on each side, one 300-cycle result stall");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
